FILE: sv/maze_carver_top_defines.svh
// assertion macros for the maze carver
`ifndef MAZE_CARVER_TOP_DEFINES_SVH
`define MAZE_CARVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("maze carver check failed");
`define MC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("maze carver check failed");
`else
`define MC_ASSERT_SAME(lbl, ante, cons)
`define MC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/mc_pkg.sv
`timescale 1ns / 1ps

package mc_pkg;

  localparam int SIDE_W     = 6;
  localparam int MAX_SIDE   = 63;
  localparam int GRID_AW    = 2 * SIDE_W;
  localparam int GRID_DEPTH = 1 << GRID_AW;
  localparam int PC_W       = 6;

  typedef logic [PC_W-1:0]    pc_t;
  typedef logic [SIDE_W-1:0]  side_t;
  typedef logic [GRID_AW-1:0] gaddr_t;

  localparam side_t SIDE_MAX = side_t'(MAX_SIDE);
  localparam side_t MIN_SIDE = side_t'(7);

  localparam logic [1:0] FN_START = 2'd0;
  localparam logic [1:0] FN_DRAW  = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {K_WALL, K_PASS, K_ENTRY, K_EXIT} kind_t;
  typedef enum logic [1:0] {PH_IDLE, PH_WALK, PH_DONE} phase_t;
  typedef enum logic [1:0] {D_COL_UP, D_ROW_UP, D_COL_DN, D_ROW_DN} dir_t;

  typedef enum logic [3:0] {
    A_NOP, A_LATCH, A_START, A_CLEAR, A_DRAW_INIT, A_NEXT_DIR, A_MOVE, A_SEED, A_SET_DONE
  } act_t;

  typedef enum logic [2:0] {
    AS_CLEAR, AS_ORIGIN, AS_READ, AS_NEAR, AS_FAR, AS_ENTRY, AS_EXIT
  } asel_t;

  typedef enum logic [2:0] {
    E_START, E_NEAR, E_FAR, E_ENTRY, E_EXIT, E_ACK, E_READ
  } esel_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_INPUT, C_FN_START, C_FN_READ, C_IGNORE, C_WALKING,
    C_CLR_MORE, C_FAR_OUT, C_NOT_WALL, C_TRIES_LEFT, C_SEED_OK
  } cond_t;

  typedef struct packed {
    act_t  act;
    asel_t asel;
    logic  we;
    kind_t wkind;
    logic  emit;
    esel_t esel;
    logic  elast;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic fn_start;
    logic fn_read;
    logic ignore;
    logic walking;
    logic clr_more;
    logic far_out;
    logic not_wall;
    logic tries_left;
    logic seed_ok;
    logic out_free;
  } stat_t;

  localparam pc_t PC_FETCH = pc_t'(0);
  localparam pc_t PC_START = pc_t'(10);
  localparam pc_t PC_CLEAR = pc_t'(11);
  localparam pc_t PC_READ  = pc_t'(20);
  localparam pc_t PC_DRAW  = pc_t'(30);
  localparam pc_t PC_NEAR  = pc_t'(31);
  localparam pc_t PC_FAIL  = pc_t'(36);

  localparam ctrl_t CTRL_NOP = '{
    act: A_NOP, asel: AS_READ, we: 1'b0, wkind: K_WALL, emit: 1'b0,
    esel: E_ACK, elast: 1'b0, cond: C_NEVER, target: PC_FETCH
  };

  function automatic side_t norm_side(side_t v);
    side_t s;
    s = v;
    if (s > SIDE_MAX) s = SIDE_MAX;
    if (!s[0] && s != '0) s = s - side_t'(1);
    if (s < MIN_SIDE) s = MIN_SIDE;
    return s;
  endfunction

  function automatic ctrl_t ucode_rom(pc_t pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      pc_t'(0): begin
        w.act = A_LATCH; w.cond = C_NO_INPUT; w.target = PC_FETCH;
      end
      pc_t'(1): begin
        w.cond = C_FN_START; w.target = PC_START;
      end
      pc_t'(2): begin
        w.cond = C_FN_READ; w.target = PC_READ;
      end
      pc_t'(3): begin
        w.cond = C_IGNORE; w.target = PC_FETCH;
      end
      pc_t'(4): begin
        w.cond = C_WALKING; w.target = PC_DRAW;
      end
      pc_t'(5): begin
        w.emit = 1'b1; w.esel = E_ACK; w.elast = 1'b1;
        w.cond = C_ALWAYS; w.target = PC_FETCH;
      end
      pc_t'(10): begin
        w.act = A_START;
      end
      pc_t'(11): begin
        w.act = A_CLEAR; w.asel = AS_CLEAR; w.we = 1'b1; w.wkind = K_WALL;
        w.cond = C_CLR_MORE; w.target = PC_CLEAR;
      end
      pc_t'(12): begin
        w.asel = AS_ORIGIN; w.we = 1'b1; w.wkind = K_PASS;
      end
      pc_t'(13): begin
        w.emit = 1'b1; w.esel = E_START; w.elast = 1'b1;
        w.cond = C_ALWAYS; w.target = PC_FETCH;
      end
      pc_t'(20): begin
        w.asel = AS_READ;
      end
      pc_t'(21): begin
        w.asel = AS_READ; w.emit = 1'b1; w.esel = E_READ; w.elast = 1'b1;
        w.cond = C_ALWAYS; w.target = PC_FETCH;
      end
      pc_t'(30): begin
        w.act = A_DRAW_INIT;
      end
      pc_t'(31): begin
        w.asel = AS_NEAR; w.cond = C_FAR_OUT; w.target = PC_FAIL;
      end
      pc_t'(32): begin
        w.asel = AS_FAR; w.cond = C_NOT_WALL; w.target = PC_FAIL;
      end
      pc_t'(33): begin
        w.cond = C_NOT_WALL; w.target = PC_FAIL;
      end
      pc_t'(34): begin
        w.asel = AS_NEAR; w.we = 1'b1; w.wkind = K_PASS;
        w.emit = 1'b1; w.esel = E_NEAR;
      end
      pc_t'(35): begin
        w.act = A_MOVE; w.asel = AS_FAR; w.we = 1'b1; w.wkind = K_PASS;
        w.emit = 1'b1; w.esel = E_FAR; w.elast = 1'b1;
        w.cond = C_ALWAYS; w.target = PC_FETCH;
      end
      pc_t'(36): begin
        w.act = A_NEXT_DIR; w.cond = C_TRIES_LEFT; w.target = PC_NEAR;
      end
      pc_t'(37): begin
        w.act = A_SEED; w.cond = C_SEED_OK; w.target = PC_FETCH;
      end
      pc_t'(38): begin
        w.act = A_SET_DONE; w.asel = AS_ENTRY; w.we = 1'b1; w.wkind = K_ENTRY;
        w.emit = 1'b1; w.esel = E_ENTRY;
      end
      pc_t'(39): begin
        w.asel = AS_EXIT; w.we = 1'b1; w.wkind = K_EXIT;
        w.emit = 1'b1; w.esel = E_EXIT; w.elast = 1'b1;
        w.cond = C_ALWAYS; w.target = PC_FETCH;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = PC_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/mc_grid.sv
`timescale 1ns / 1ps

module mc_grid (
  input  logic           clk,
  input  logic           we,
  input  mc_pkg::gaddr_t addr,
  input  mc_pkg::kind_t  wdata,
  output mc_pkg::kind_t  rdata
);
  import mc_pkg::*;

  logic [1:0] mem [GRID_DEPTH];
  logic [1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[addr];
  end

  assign rdata = kind_t'(rdata_r);

endmodule

FILE: sv/mc_dpath.sv
`timescale 1ns / 1ps
`include "maze_carver_top_defines.svh"

module mc_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  mc_pkg::ctrl_t     ctrl,
  output mc_pkg::stat_t     stat,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_func,
  input  logic [1:0]        in_dir,
  input  mc_pkg::side_t     in_read_row,
  input  mc_pkg::side_t     in_read_col,
  output logic              out_tvalid,
  input  logic              out_tready,
  output mc_pkg::side_t     out_row,
  output mc_pkg::side_t     out_col,
  output mc_pkg::kind_t     out_kind,
  output logic              out_done,
  output logic              out_last,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  mc_pkg::side_t     cfg_data
);
  import mc_pkg::*;

  logic [1:0] func_r;
  dir_t       dir_in_r;
  side_t      read_row_r, read_col_r;
  dir_t       dir_r;
  logic [1:0] try_r;
  side_t      walk_row_r, walk_col_r, seed_row_r, seed_col_r;
  side_t      width_r, height_r;
  phase_t     phase_r;
  gaddr_t     clr_r;

  logic       out_valid_r, out_done_r, out_last_r;
  side_t      out_row_r, out_col_r;
  kind_t      out_kind_r;

  logic       in_fire, out_free, advance, emit_fire;
  logic signed [7:0] dr_s, dc_s, wr_s, wc_s, r1_s, c1_s, r2_s, c2_s, h_s, w_s;
  logic       far_ok;
  logic [6:0] sc_inc, sr_nxt, sc_nxt;
  logic       seed_ok;
  logic       rd_in;
  gaddr_t     g_addr;
  kind_t      g_rdata;
  side_t      e_row, e_col;
  kind_t      e_kind;
  logic       e_done;

  assign in_tready = (ctrl.act == A_LATCH);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = !ctrl.emit || out_free;
  assign emit_fire = ctrl.emit && out_free;

  // step geometry of the current try
  always_comb begin
    unique case (dir_r)
      D_COL_UP: begin dr_s = 8'sd0;  dc_s = 8'sd1;  end
      D_ROW_UP: begin dr_s = 8'sd1;  dc_s = 8'sd0;  end
      D_COL_DN: begin dr_s = 8'sd0;  dc_s = -8'sd1; end
      D_ROW_DN: begin dr_s = -8'sd1; dc_s = 8'sd0;  end
      default:  begin dr_s = 8'sd0;  dc_s = 8'sd0;  end
    endcase
  end

  assign wr_s = $signed({2'b00, walk_row_r});
  assign wc_s = $signed({2'b00, walk_col_r});
  assign h_s  = $signed({2'b00, height_r});
  assign w_s  = $signed({2'b00, width_r});
  assign r1_s = wr_s + dr_s;
  assign c1_s = wc_s + dc_s;
  assign r2_s = r1_s + dr_s;
  assign c2_s = c1_s + dc_s;
  assign far_ok = (r2_s > 8'sd0) && (r2_s < h_s) && (c2_s > 8'sd0) && (c2_s < w_s);

  // next seed in row-major order
  always_comb begin
    sc_inc = {1'b0, seed_col_r} + 7'd2;
    if (sc_inc >= {1'b0, width_r}) begin
      sc_nxt = 7'd1;
      sr_nxt = {1'b0, seed_row_r} + 7'd2;
    end else begin
      sc_nxt = sc_inc;
      sr_nxt = {1'b0, seed_row_r};
    end
  end
  assign seed_ok = sr_nxt < {1'b0, height_r};

  always_comb begin
    unique case (ctrl.asel)
      AS_CLEAR:  g_addr = clr_r;
      AS_ORIGIN: g_addr = {side_t'(1), side_t'(1)};
      AS_READ:   g_addr = {read_row_r, read_col_r};
      AS_NEAR:   g_addr = {r1_s[SIDE_W-1:0], c1_s[SIDE_W-1:0]};
      AS_FAR:    g_addr = {r2_s[SIDE_W-1:0], c2_s[SIDE_W-1:0]};
      AS_ENTRY:  g_addr = {side_t'(0), side_t'(1)};
      AS_EXIT:   g_addr = {height_r - side_t'(1), width_r - side_t'(2)};
      default:   g_addr = clr_r;
    endcase
  end

  mc_grid u_grid (
    .clk   (clk),
    .we    (ctrl.we && advance),
    .addr  (g_addr),
    .wdata (ctrl.wkind),
    .rdata (g_rdata)
  );

  // grid is only trusted once a start has swept it
  assign rd_in = (read_row_r < height_r) && (read_col_r < width_r) && (phase_r != PH_IDLE);

  always_comb begin
    unique case (ctrl.esel)
      E_START: begin
        e_row = side_t'(1); e_col = side_t'(1); e_kind = K_PASS; e_done = 1'b0;
      end
      E_NEAR: begin
        e_row = r1_s[SIDE_W-1:0]; e_col = c1_s[SIDE_W-1:0]; e_kind = K_PASS; e_done = 1'b0;
      end
      E_FAR: begin
        e_row = r2_s[SIDE_W-1:0]; e_col = c2_s[SIDE_W-1:0]; e_kind = K_PASS; e_done = 1'b0;
      end
      E_ENTRY: begin
        e_row = side_t'(0); e_col = side_t'(1); e_kind = K_ENTRY; e_done = 1'b1;
      end
      E_EXIT: begin
        e_row = height_r - side_t'(1); e_col = width_r - side_t'(2);
        e_kind = K_EXIT; e_done = 1'b1;
      end
      E_ACK: begin
        e_row = '0; e_col = '0; e_kind = K_WALL; e_done = 1'b1;
      end
      E_READ: begin
        e_row = read_row_r; e_col = read_col_r;
        e_kind = rd_in ? g_rdata : K_WALL;
        e_done = (phase_r == PH_DONE);
      end
      default: begin
        e_row = '0; e_col = '0; e_kind = K_WALL; e_done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r     <= in_func;
      dir_in_r   <= dir_t'(in_dir);
      read_row_r <= in_read_row;
      read_col_r <= in_read_col;
    end
    if (advance) begin
      unique case (ctrl.act)
        A_START:     clr_r <= '0;
        A_CLEAR:     clr_r <= clr_r + gaddr_t'(1);
        A_DRAW_INIT: begin
          dir_r <= dir_in_r;
          try_r <= 2'd0;
        end
        A_NEXT_DIR: begin
          dir_r <= dir_t'(dir_r + 2'd1);
          try_r <= try_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_row_r <= side_t'(1);
      walk_col_r <= side_t'(1);
      seed_row_r <= side_t'(1);
      seed_col_r <= side_t'(1);
      phase_r    <= PH_IDLE;
      width_r    <= SIDE_MAX;
      height_r   <= SIDE_MAX;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_WIDTH) width_r <= norm_side(cfg_data);
        if (cfg_index == REG_HEIGHT) height_r <= norm_side(cfg_data);
      end
      if (advance) begin
        unique case (ctrl.act)
          A_START: begin
            walk_row_r <= side_t'(1);
            walk_col_r <= side_t'(1);
            seed_row_r <= side_t'(1);
            seed_col_r <= side_t'(1);
            phase_r    <= PH_WALK;
          end
          A_MOVE: begin
            walk_row_r <= r2_s[SIDE_W-1:0];
            walk_col_r <= c2_s[SIDE_W-1:0];
          end
          A_SEED: begin
            if (seed_ok) begin
              seed_row_r <= sr_nxt[SIDE_W-1:0];
              seed_col_r <= sc_nxt[SIDE_W-1:0];
              walk_row_r <= sr_nxt[SIDE_W-1:0];
              walk_col_r <= sc_nxt[SIDE_W-1:0];
            end
          end
          A_SET_DONE: phase_r <= PH_DONE;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_row_r  <= e_row;
      out_col_r  <= e_col;
      out_kind_r <= e_kind;
      out_done_r <= e_done;
      out_last_r <= ctrl.elast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_kind   = out_kind_r;
  assign out_done   = out_done_r;
  assign out_last   = out_last_r;

  assign stat.in_fire    = in_fire;
  assign stat.fn_start   = (func_r == FN_START);
  assign stat.fn_read    = (func_r == FN_READ);
  assign stat.ignore     = (func_r != FN_DRAW) || (phase_r == PH_IDLE);
  assign stat.walking    = (phase_r == PH_WALK);
  assign stat.clr_more   = (clr_r != '1);
  assign stat.far_out    = !far_ok;
  assign stat.not_wall   = (g_rdata != K_WALL);
  assign stat.tries_left = (try_r != 2'd3);
  assign stat.seed_ok    = seed_ok;
  assign stat.out_free   = out_free;

  `MC_ASSERT_SAME(a_idle_home, phase_r == PH_IDLE, walk_row_r == side_t'(1) && walk_col_r == side_t'(1) && seed_row_r == side_t'(1) && seed_col_r == side_t'(1))
  `MC_ASSERT_SAME(a_walk_odd, phase_r == PH_WALK, walk_row_r[0] && walk_col_r[0] && seed_row_r[0] && seed_col_r[0])
  `MC_ASSERT_NEXT(a_emit_lands, emit_fire, out_valid_r)

endmodule

FILE: sv/mc_seq.sv
`timescale 1ns / 1ps
`include "maze_carver_top_defines.svh"

module mc_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  mc_pkg::stat_t stat,
  output mc_pkg::ctrl_t ctrl
);
  import mc_pkg::*;

  pc_t  pc_r, pc_nxt;
  logic taken, advance;

  assign ctrl    = ucode_rom(pc_r);
  assign advance = !ctrl.emit || stat.out_free;

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_NO_INPUT:   taken = !stat.in_fire;
      C_FN_START:   taken = stat.fn_start;
      C_FN_READ:    taken = stat.fn_read;
      C_IGNORE:     taken = stat.ignore;
      C_WALKING:    taken = stat.walking;
      C_CLR_MORE:   taken = stat.clr_more;
      C_FAR_OUT:    taken = stat.far_out;
      C_NOT_WALL:   taken = stat.not_wall;
      C_TRIES_LEFT: taken = stat.tries_left;
      C_SEED_OK:    taken = stat.seed_ok;
      default:      taken = 1'b1;
    endcase
  end

  always_comb begin
    priority if (!advance) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `MC_ASSERT_NEXT(a_leave_fetch, stat.in_fire, pc_r != PC_FETCH)
  `MC_ASSERT_NEXT(a_hold_on_stall, ctrl.emit && !stat.out_free, $stable(pc_r))

endmodule

FILE: sv/maze_carver_top.sv
`timescale 1ns / 1ps
// channel  dir  handshake                 payload
// in_      in   in_tvalid / in_tready     tdata, tuser (func)
// out_     out  out_tvalid / out_tready   tdata, tuser, tlast
// cfg_     in   cfg_valid / cfg_ready     cfg_index, cfg_data
// one item at a time from a microcode program driving a single-port grid memory
// a start does one clearing write per grid entry; a read looks up one cell; a draw carves
// on a first try or after failed tries, and marks entry and exit when the last walk ends
// reset clears control only; the grid is swept by each start, before that reads give wall
// one result register on the output; the program waits at a result step while it is full

module maze_carver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // random_direction, read_row, read_col
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // cell_row, cell_col
  output logic [2:0]  out_tuser,  // cell_kind, gen_done
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  import mc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  side_t o_row, o_col;
  kind_t o_kind;
  logic  o_done;

  assign cfg_ready = 1'b1;

  mc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  mc_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_func     (in_tuser),
    .in_dir      (in_tdata[1:0]),
    .in_read_row (in_tdata[7:2]),
    .in_read_col (in_tdata[13:8]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_row     (o_row),
    .out_col     (o_col),
    .out_kind    (o_kind),
    .out_done    (o_done),
    .out_last    (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  assign out_tdata = {4'b0000, o_col, o_row};
  assign out_tuser = {o_done, o_kind};

endmodule
